>>> rtl/core/signed_integer_to_radix_digits_assert.svh
// assertion macros for the port checker
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srd assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srd assertion failed");

`endif

>>> rtl/core/srd_pkg.sv
// shared types and constants of the radix digit converter
package srd_pkg;

    localparam int SYM_W   = 8;
    localparam int BASE_W  = 5;
    localparam int ALPHA_W = 64;

    localparam logic [SYM_W-1:0]  SYM_MINUS = 8'd45;
    localparam logic [SYM_W-1:0]  SYM_PLUS  = 8'd43;
    localparam logic [BASE_W-1:0] MIN_BASE  = 5'd2;

    typedef struct packed {
        logic clear;
        logic shift;
    } srd_cell_ctrl_t;

endpackage

>>> rtl/core/srd_alpha_chk.sv
// alphabet validity check: size range, sign symbols, repeated symbols
module srd_alpha_chk
    import srd_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16
)
(
    input  logic [2*ALPHA_W-1:0] alphabet,
    input  logic [BASE_W-1:0]    base_size,
    output logic                 bad
);

    logic [SYM_W-1:0] sym [MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0] in_use;

    always_comb
    begin
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            sym[i]    = alphabet[i*SYM_W +: SYM_W];
            in_use[i] = BASE_W'(i) < base_size;
        end
    end

    always_comb
    begin
        bad = (base_size < MIN_BASE) || (base_size > BASE_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (in_use[i] && (sym[i] == SYM_MINUS || sym[i] == SYM_PLUS))
            begin
                bad = 1'b1;
            end
            // symbol j in use implies symbol i in use for i below j
            for (int j = i + 1; j < MAX_SYMBOLS; j++)
            begin
                if (in_use[j] && sym[i] == sym[j])
                begin
                    bad = 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/core/srd_cell.sv
// one digit cell: clears, doubles its digit plus carry modulo the base, or shifts up
module srd_cell
    import srd_pkg::*;
#(
    parameter int DIG_W = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  srd_cell_ctrl_t       ctrl,
    input  logic [BASE_W-1:0]    base,
    input  logic                 carry_in,
    input  logic                 en_in,
    input  logic [DIG_W-1:0]     shift_in,
    output logic [DIG_W-1:0]     digit,
    output logic                 carry_out,
    output logic                 en_out
);

    logic [DIG_W-1:0]  digit_reg, digit_next;
    logic              carry_reg, carry_next;
    logic              en_reg, en_next;
    logic [BASE_W-1:0] dbl;
    logic [BASE_W-1:0] red;
    logic              ge;

    assign dbl = BASE_W'({digit_reg, carry_in});
    assign ge  = dbl >= base;
    assign red = ge ? dbl - base : dbl;

    always_comb
    begin
        digit_next = digit_reg;
        carry_next = 1'b0;
        en_next    = 1'b0;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift)
        begin
            digit_next = shift_in;
        end
        else if (en_in)
        begin
            digit_next = DIG_W'(red);
            carry_next = ge;
            en_next    = 1'b1;
        end
    end

    // carry and its enable travel one cell per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
            carry_reg <= 1'b0;
            en_reg    <= 1'b0;
        end
        else
        begin
            digit_reg <= digit_next;
            carry_reg <= carry_next;
            en_reg    <= en_next;
        end
    end

    assign digit     = digit_reg;
    assign carry_out = carry_reg;
    assign en_out    = en_reg;

endmodule

>>> rtl/core/signed_integer_to_radix_digits.sv
// signed integer to radix digits converter, top level
//
// Input channel: in_valid / in_stall with the signed value on number. The
// block takes one value at a time; in_stall is high from the cycle after a
// transaction until the last character has been handed to the output register.
// Output channel: out_valid / out_stall with symbol, last and bad_base, one
// character per transaction, most significant digit first, '-' ahead of the
// digits of a negative value. last marks the final character of a value.
// An invalid alphabet gives one transaction with bad_base and last set, symbol 0.
// Configuration: cfg_we writes cfg_data to register cfg_index (alphabet low,
// alphabet high, base size); the user writes only while the block is idle, the block does not enforce it.
// Operation: the magnitude enters a row of NUMBER_BITS digit cells one bit per
// cycle and the carries ripple one cell per cycle; the digits then shift out of
// the top cell, leading zeros at one per cycle. A stalled receiver freezes the
// character stream while the output register holds its transaction. Reset
// clears the registers to zero but sets the alphabet error flag, and leaves
// the block idle with an invalid alphabet.
module signed_integer_to_radix_digits
    import srd_pkg::*;
#(
    parameter int MAX_SYMBOLS = 16,
    parameter int NUMBER_BITS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [ALPHA_W-1:0]            cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [NUMBER_BITS-1:0] number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [SYM_W-1:0]              symbol,
    output logic                          last,
    output logic                          bad_base
);

    localparam int DIG_W     = $clog2(MAX_SYMBOLS);
    localparam int NUM_CELLS = NUMBER_BITS;
    localparam int CNT_W     = $clog2(NUMBER_BITS + NUM_CELLS);
    localparam int REM_W     = $clog2(NUM_CELLS + 1);
    localparam int CONV_LAST = NUMBER_BITS + NUM_CELLS - 2;

    localparam logic [1:0] CFG_ALPHA_LOW  = 2'd0;
    localparam logic [1:0] CFG_ALPHA_HIGH = 2'd1;
    localparam logic [1:0] CFG_BASE_SIZE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } state_t;

    // configuration registers
    logic [ALPHA_W-1:0]   alpha_low_reg;
    logic [ALPHA_W-1:0]   alpha_high_reg;
    logic [BASE_W-1:0]    base_size_reg;
    logic [2*ALPHA_W-1:0] alpha_all;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            base_size_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALPHA_LOW:  alpha_low_reg  <= cfg_data;
                CFG_ALPHA_HIGH: alpha_high_reg <= cfg_data;
                CFG_BASE_SIZE:  base_size_reg  <= cfg_data[BASE_W-1:0];
                default:        ;
            endcase
        end
    end

    assign alpha_all = {alpha_high_reg, alpha_low_reg};

    logic bad_comb;
    logic bad_q_reg;

    srd_alpha_chk #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_alpha_chk (
        .alphabet  (alpha_all),
        .base_size (base_size_reg),
        .bad       (bad_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_q_reg <= 1'b1;
        end
        else
        begin
            bad_q_reg <= bad_comb;
        end
    end

    // control and datapath registers
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [NUMBER_BITS-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]       symbol_reg, symbol_next;
    logic                   last_reg, last_next;
    logic                   bad_base_reg, bad_base_next;

    srd_cell_ctrl_t   cell_ctrl;
    logic             do_shift;
    logic             in_take;
    logic             slot_free;
    logic             cell0_en;
    logic [DIG_W-1:0] digit [NUM_CELLS];
    logic             carry [NUM_CELLS];
    logic             en    [NUM_CELLS];
    logic [DIG_W-1:0] top_digit;
    logic             top_zero;
    logic [NUMBER_BITS-1:0] num_u;
    logic [SYM_W-1:0] top_symbol;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign slot_free  = !out_valid_reg || !out_stall;
    assign cell0_en   = (state_reg == S_CONV) && (cnt_reg < CNT_W'(NUMBER_BITS));
    assign top_digit  = digit[NUM_CELLS-1];
    assign top_zero   = (top_digit == '0);
    assign num_u      = number;
    assign top_symbol = alpha_all[4'(top_digit)*SYM_W +: SYM_W];

    assign cell_ctrl.clear = in_take;
    assign cell_ctrl.shift = do_shift;

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            srd_cell #(
                .DIG_W (DIG_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .base      (base_size_reg),
                .carry_in  (mag_reg[NUMBER_BITS-1]),
                .en_in     (cell0_en),
                .shift_in  ('0),
                .digit     (digit[g]),
                .carry_out (carry[g]),
                .en_out    (en[g])
            );
        end
        else
        begin : g_rest
            srd_cell #(
                .DIG_W (DIG_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .base      (base_size_reg),
                .carry_in  (carry[g-1]),
                .en_in     (en[g-1]),
                .shift_in  (digit[g-1]),
                .digit     (digit[g]),
                .carry_out (carry[g]),
                .en_out    (en[g])
            );
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && out_stall;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        bad_base_next  = bad_base_reg;
        do_shift       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    neg_next   = num_u[NUMBER_BITS-1];
                    mag_next   = num_u[NUMBER_BITS-1] ? (~num_u + 1'b1) : num_u;
                    cnt_next   = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!bad_q_reg)
                begin
                    state_next = S_CONV;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = '0;
                    last_next      = 1'b1;
                    bad_base_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CONV:
            begin
                // magnitude enters the cell row msb first
                mag_next = {mag_reg[NUMBER_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CONV_LAST))
                begin
                    rem_next   = REM_W'(NUM_CELLS);
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (!top_zero || rem_reg == REM_W'(1))
                begin
                    state_next = neg_reg ? S_SIGN : S_EMIT;
                end
                else
                begin
                    do_shift = 1'b1;
                    rem_next = rem_reg - 1'b1;
                end
            end
            S_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = SYM_MINUS;
                    last_next      = 1'b0;
                    bad_base_next  = 1'b0;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = top_symbol;
                    last_next      = (rem_reg == REM_W'(1));
                    bad_base_next  = 1'b0;
                    do_shift       = 1'b1;
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            symbol_reg    <= '0;
            last_reg      <= 1'b0;
            bad_base_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
            symbol_reg    <= symbol_next;
            last_reg      <= last_next;
            bad_base_reg  <= bad_base_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;
    assign bad_base  = bad_base_reg;

endmodule

>>> rtl/core/srd_checker.sv
// port checker for the radix digit converter, bound to the top level
`include "signed_integer_to_radix_digits_assert.svh"

module srd_checker
    import srd_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [SYM_W-1:0]              symbol,
    input logic                          last,
    input logic                          bad_base
);

    // a stalled output transaction holds
    `SRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(symbol) && $stable(last) && $stable(bad_base))

    // the error transaction is a single one with a zero symbol
    `SRD_ASSERT_NOW(a_err_form, out_valid && bad_base, last && symbol == '0)

    // one value at a time: input stalls right after a transaction
    `SRD_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall)

    // a minus sign is always followed by digits
    `SRD_ASSERT_NOW(a_sign_not_last, out_valid && !bad_base && symbol == SYM_MINUS, !last)

endmodule

bind signed_integer_to_radix_digits srd_checker u_srd_checker (.*);

>>> tb/tb_signed_integer_to_radix_digits.sv
// self-checking testbench for the signed integer to radix digits converter
module tb_signed_integer_to_radix_digits;
    import srd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SYMBOLS = 16;
    localparam int NUMBER_BITS = 32;
    localparam int STALL_PCT = 19;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 23;
    localparam int ITEMS_PER_PHASE = 20;

    localparam logic [1:0] REG_ALPHA_LO  = 2'd0;
    localparam logic [1:0] REG_ALPHA_HI  = 2'd1;
    localparam logic [1:0] REG_BASE_SIZE = 2'd2;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             bad;
    } char_t;

    class digit_scoreboard;
        logic [ALPHA_W-1:0] alpha_lo;
        logic [ALPHA_W-1:0] alpha_hi;
        logic [BASE_W-1:0]  radix;
        char_t              expected_chars[$];
        int                 errors;

        function new();
            alpha_lo = '0;
            alpha_hi = '0;
            radix    = '0;
            errors   = 0;
        endfunction

        function void load_alphabet(logic [ALPHA_W-1:0] lo, logic [ALPHA_W-1:0] hi,
                                    logic [BASE_W-1:0] sz);
            alpha_lo = lo;
            alpha_hi = hi;
            radix    = sz;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function logic [SYM_W-1:0] symbol_of(int idx);
            if (idx < 8)
                return alpha_lo[idx*8 +: 8];
            return alpha_hi[(idx-8)*8 +: 8];
        endfunction

        function bit alphabet_invalid();
            if (radix < MIN_BASE || radix > MAX_SYMBOLS)
                return 1'b1;
            for (int i = 0; i < radix; i++)
            begin
                if (symbol_of(i) == SYM_MINUS || symbol_of(i) == SYM_PLUS)
                    return 1'b1;
                for (int j = i + 1; j < radix; j++)
                    if (symbol_of(j) == symbol_of(i))
                        return 1'b1;
            end
            return 1'b0;
        endfunction

        // works out the characters that one accepted number must produce
        function void note_number(logic signed [NUMBER_BITS-1:0] value);
            logic [63:0] mag;
            logic [3:0]  digits[$];
            char_t       c;
            if (alphabet_invalid())
            begin
                c.sym  = '0;
                c.last = 1'b1;
                c.bad  = 1'b1;
                expected_chars.push_back(c);
                return;
            end
            mag = {32'b0, value};
            if (value[NUMBER_BITS-1])
                mag = (~mag + 64'd1) & 64'hFFFF_FFFF;
            do
            begin
                digits.push_front(4'(mag % radix));
                mag = mag / radix;
            end
            while (mag != 0);
            if (value[NUMBER_BITS-1])
            begin
                c.sym  = SYM_MINUS;
                c.last = 1'b0;
                c.bad  = 1'b0;
                expected_chars.push_back(c);
            end
            foreach (digits[k])
            begin
                c.sym  = symbol_of(digits[k]);
                c.last = (k == digits.size() - 1);
                c.bad  = 1'b0;
                expected_chars.push_back(c);
            end
        endfunction

        function void check_char(logic [SYM_W-1:0] sym, logic last, logic bad);
            char_t want;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character symbol %h last %b bad_base %b",
                         $time, sym, last, bad);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            if (sym !== want.sym)
            begin
                $display("%0t: symbol expected %h actual %h", $time, want.sym, sym);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last expected %b actual %b", $time, want.last, last);
                errors++;
            end
            if (bad !== want.bad)
            begin
                $display("%0t: bad_base expected %b actual %b", $time, want.bad, bad);
                errors++;
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [1:0]                    cfg_index = REG_ALPHA_LO;
    logic [ALPHA_W-1:0]            cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [NUMBER_BITS-1:0] number = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [SYM_W-1:0]              symbol;
    logic                          last;
    logic                          bad_base;

    digit_scoreboard sb = new();
    bit              no_gaps = 1'b0;
    int              quiet_cycles = 0;

    signed_integer_to_radix_digits #(
        .MAX_SYMBOLS(MAX_SYMBOLS),
        .NUMBER_BITS(NUMBER_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .number(number),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .symbol(symbol),
        .last(last),
        .bad_base(bad_base)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= !no_gaps && ($urandom_range(99) < STALL_PCT);
    end

    // both channels are observed with the values held just before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (in_valid && !in_stall)
                sb.note_number(number);
            if (out_valid && !out_stall)
                sb.check_char(symbol, last, bad_base);
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_number(input logic signed [NUMBER_BITS-1:0] value);
        if (!no_gaps && $urandom_range(99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= value;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // registers only change once the converter has gone idle
    task automatic configure(input logic [ALPHA_W-1:0] lo, input logic [ALPHA_W-1:0] hi,
                             input logic [BASE_W-1:0] sz);
        logic [ALPHA_W-1:0] size_word;
        wait_drained();
        size_word = {$urandom, $urandom};
        size_word[BASE_W-1:0] = sz;
        cfg_we    <= 1'b1;
        cfg_index <= REG_ALPHA_LO;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_ALPHA_HI;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= REG_BASE_SIZE;
        cfg_data  <= size_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.load_alphabet(lo, hi, sz);
    endtask

    // distinct legal symbols in use, anything at all in the unused slots
    function automatic logic [127:0] make_alphabet(int sz);
        bit               used[256];
        logic [SYM_W-1:0] s;
        logic [127:0]     all;
        all = {$urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < sz; i++)
        begin
            do
                s = SYM_W'($urandom_range(255));
            while (used[s] || s == SYM_PLUS || s == SYM_MINUS);
            used[s] = 1'b1;
            all[i*8 +: 8] = s;
        end
        return all;
    endfunction

    function automatic logic signed [NUMBER_BITS-1:0] pick_number();
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(600) - 300;
            6:          v = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                              : 32'h7FFF_FFFF - $urandom_range(3);
            default:
            begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    initial
    begin
        logic [127:0] alpha;
        int           sz;
        int           i;
        int           j;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // alphabet after reset is empty
        send_number(0);
        send_number(-1);

        configure(64'h3736_3534_3332_3130, 64'h2B2D_0000_FFFF_3938, 5'd10);
        send_number(0);
        send_number(7);
        send_number(-7);
        send_number(32'sh7FFF_FFFF);
        send_number(32'sh8000_0000);
        send_number(10);
        send_number(-10);

        // binary with a zero byte symbol, sign characters parked in unused slots
        configure(64'h2D2B_2D2B_2D2B_FF00, 64'h2B2B_2D2D_0000_0000, 5'd2);
        send_number(32'sh8000_0000);
        send_number(32'sh7FFF_FFFF);
        send_number(0);
        send_number(1);

        configure(64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, 5'd16);
        send_number(-1);
        send_number(255);
        send_number(16);
        send_number(32'sh8000_0000);

        // one symbol only
        configure(64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, 5'd1);
        send_number(5);
        // oversized base
        configure(64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, 5'd17);
        send_number(-5);
        configure('0, '0, 5'd31);
        send_number(3);
        // minus sign inside the used range
        configure(64'h3736_3534_2D32_3130, 64'h6665_6463_6261_3938, 5'd10);
        send_number(12);
        // plus sign as the top symbol
        configure(64'h3736_3534_3332_3130, 64'h2B65_6463_6261_3938, 5'd16);
        send_number(12);
        // repeated symbol far apart
        configure(64'h3736_3534_3332_3130, 64'h3065_6463_6261_3938, 5'd16);
        send_number(-12);
        // plus sign just past the used range is harmless
        configure(64'h3736_3534_3332_3130, 64'h6665_6463_612B_3938, 5'd10);
        send_number(-123);
        configure('1, '1, 5'd16);
        send_number(1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            no_gaps = (p >= 8 && p < 11);
            case ($urandom_range(9))
                0, 1, 2: sz = 2;
                3, 4, 5: sz = MAX_SYMBOLS;
                default: sz = $urandom_range(3, MAX_SYMBOLS - 1);
            endcase
            alpha = make_alphabet(sz);
            if ($urandom_range(9) < 2)
            begin
                case ($urandom_range(4))
                    0: sz = $urandom_range(1);
                    1: sz = $urandom_range(MAX_SYMBOLS + 1, 31);
                    2: alpha[8*$urandom_range(sz-1) +: 8] = SYM_MINUS;
                    3: alpha[8*$urandom_range(sz-1) +: 8] = SYM_PLUS;
                    default:
                    begin
                        i = $urandom_range(sz - 2);
                        j = $urandom_range(i + 1, sz - 1);
                        alpha[8*j +: 8] = alpha[8*i +: 8];
                    end
                endcase
            end
            configure(alpha[63:0], alpha[127:64], BASE_W'(sz));
            repeat (ITEMS_PER_PHASE) send_number(pick_number());
        end
        no_gaps = 1'b0;

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
